>>> rtl/core/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg: shared types and constants of the sorted color bucket
// Holds the store geometry, status codes, register indexes and the
// command and status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package scb_pkg;

    localparam int MaxPoints = 256;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CountW    = $clog2(MaxPoints + 1);
    localparam int SumW      = 8 + CountW;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_OUTSIDE   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;

    localparam logic [2:0] REG_LOW_RED    = 3'd0;
    localparam logic [2:0] REG_LOW_GREEN  = 3'd1;
    localparam logic [2:0] REG_LOW_BLUE   = 3'd2;
    localparam logic [2:0] REG_SIZE_RED   = 3'd3;
    localparam logic [2:0] REG_SIZE_GREEN = 3'd4;
    localparam logic [2:0] REG_SIZE_BLUE  = 3'd5;
    localparam logic [2:0] REG_CAPACITY   = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_DECIDE,
        S_INS_RD,
        S_INS_WR,
        S_REM_RD,
        S_REM_WR,
        S_DIV,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input beat, start search
        logic srch_rd;    // issue read at search midpoint
        logic srch_cmp;   // narrow search window
        logic decide;     // evaluate status
        logic shift_init; // set shift pointer
        logic shift_rd;   // read entry to move
        logic shift_wr;   // write moved entry, step pointer
        logic key_wr;     // write key at insert position
        logic commit;     // update count and sums
        logic div_start;
        logic div_step;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic srch_done;
        logic do_insert;
        logic do_remove;
        logic shift_done;
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/core/scb_ctrl.sv
// ----------------------------------------------------------------------------
// scb_ctrl: sequencer of the sorted color bucket
// Steps one beat through search, decision, shift, division and output.
// ----------------------------------------------------------------------------
`default_nettype none
module scb_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  wire logic           out_stall,
    input  wire scb_pkg::stat_t st,
    output scb_pkg::cmd_t       cmd
);

    scb_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scb_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        unique case (state_reg)
            scb_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = scb_pkg::S_SRCH_RD;
                end
            end
            scb_pkg::S_SRCH_RD:
            begin
                if (st.srch_done)
                begin
                    cmd.decide = 1'b1;
                    state_next = scb_pkg::S_DECIDE;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = scb_pkg::S_SRCH_CMP;
                end
            end
            scb_pkg::S_SRCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
                state_next   = scb_pkg::S_SRCH_RD;
            end
            scb_pkg::S_DECIDE:
            begin
                cmd.shift_init = 1'b1;
                if (st.do_insert)
                begin
                    state_next = scb_pkg::S_INS_RD;
                end
                else if (st.do_remove)
                begin
                    state_next = scb_pkg::S_REM_RD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = scb_pkg::S_DIV;
                end
            end
            scb_pkg::S_INS_RD:
            begin
                if (st.shift_done)
                begin
                    cmd.key_wr    = 1'b1;
                    cmd.commit    = 1'b1;
                    state_next    = scb_pkg::S_DIV;
                    cmd.div_start = 1'b1;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = scb_pkg::S_INS_WR;
                end
            end
            scb_pkg::S_INS_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = scb_pkg::S_INS_RD;
            end
            scb_pkg::S_REM_RD:
            begin
                if (st.shift_done)
                begin
                    cmd.commit    = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = scb_pkg::S_DIV;
                end
                else
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = scb_pkg::S_REM_WR;
                end
            end
            scb_pkg::S_REM_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = scb_pkg::S_REM_RD;
            end
            scb_pkg::S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = scb_pkg::S_OUT;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            scb_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = scb_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = scb_pkg::S_IDLE;
            end
        endcase
    end

    ap_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.shift_wr && cmd.key_wr))
        else $error("shift and key write together");
    ap_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == scb_pkg::S_IDLE)
        else $error("load outside idle");
    ap_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

endmodule
`default_nettype wire

>>> rtl/core/scb_dp.sv
// ----------------------------------------------------------------------------
// scb_dp: datapath of the sorted color bucket
// Sorted point memory, binary search window, shift pointer, running sums
// and a restoring divider shared by the three mean channels.
// ----------------------------------------------------------------------------
`default_nettype none
module scb_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire scb_pkg::cmd_t cmd,
    output scb_pkg::stat_t     st,
    input  wire logic          func,
    input  wire logic [7:0]    red,
    input  wire logic [7:0]    green,
    input  wire logic [7:0]    blue,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [8:0]    cfg_data,
    output logic [2:0]         status,
    output logic [8:0]         point_count,
    output logic [7:0]         mean_red,
    output logic [7:0]         mean_green,
    output logic [7:0]         mean_blue
);

    localparam int AW = scb_pkg::AddrW;
    localparam int CW = scb_pkg::CountW;
    localparam int SW = scb_pkg::SumW;
    localparam int DivSteps = 8;

    logic [23:0] mem [scb_pkg::MaxPoints];
    logic [23:0] rd_reg;

    logic [7:0] low_r_reg, low_g_reg, low_b_reg;
    logic [8:0] size_r_reg, size_g_reg, size_b_reg, cap_reg;

    logic          func_reg;
    logic [23:0]   key_reg;
    logic [CW-1:0] lo_reg, hi_reg, ptr_reg, count_reg;
    logic [SW-1:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [2:0]    status_reg;
    logic          ins_reg, rem_reg;

    logic [CW-1:0] mid;
    logic          found, in_box, full;
    logic [CW-1:0] limit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_r_reg  <= '0;
            low_g_reg  <= '0;
            low_b_reg  <= '0;
            size_r_reg <= 9'd256;
            size_g_reg <= 9'd256;
            size_b_reg <= 9'd256;
            cap_reg    <= 9'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                scb_pkg::REG_LOW_RED:    low_r_reg  <= cfg_data[7:0];
                scb_pkg::REG_LOW_GREEN:  low_g_reg  <= cfg_data[7:0];
                scb_pkg::REG_LOW_BLUE:   low_b_reg  <= cfg_data[7:0];
                scb_pkg::REG_SIZE_RED:   size_r_reg <= cfg_data;
                scb_pkg::REG_SIZE_GREEN: size_g_reg <= cfg_data;
                scb_pkg::REG_SIZE_BLUE:  size_b_reg <= cfg_data;
                scb_pkg::REG_CAPACITY:   cap_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign found  = (lo_reg < count_reg) && (rd_reg == key_reg);
    assign in_box = ({2'b0, key_reg[23:16]} >= {2'b0, low_r_reg})
                 && ({2'b0, key_reg[23:16]} < {2'b0, low_r_reg} + {1'b0, size_r_reg})
                 && ({2'b0, key_reg[15:8]} >= {2'b0, low_g_reg})
                 && ({2'b0, key_reg[15:8]} < {2'b0, low_g_reg} + {1'b0, size_g_reg})
                 && ({2'b0, key_reg[7:0]} >= {2'b0, low_b_reg})
                 && ({2'b0, key_reg[7:0]} < {2'b0, low_b_reg} + {1'b0, size_b_reg});
    assign limit  = (CW'(cap_reg) < CW'(scb_pkg::MaxPoints))
                  ? CW'(cap_reg) : CW'(scb_pkg::MaxPoints);
    assign full   = count_reg >= limit;

    // memory port: one read address, one write address
    logic [AW-1:0] rd_addr, wr_addr;
    logic [23:0]   wr_data;
    logic          mem_rd, mem_we;

    always_comb
    begin
        mem_rd  = 1'b0;
        rd_addr = mid[AW-1:0];
        mem_we  = 1'b0;
        wr_addr = ptr_reg[AW-1:0];
        wr_data = rd_reg;
        if (cmd.srch_rd)
        begin
            mem_rd  = 1'b1;
            rd_addr = mid[AW-1:0];
        end
        else if (cmd.decide)
        begin
            mem_rd  = 1'b1;
            rd_addr = lo_reg[AW-1:0];
        end
        else if (cmd.shift_rd)
        begin
            mem_rd  = 1'b1;
            rd_addr = ins_reg ? AW'(ptr_reg - 1'b1) : AW'(ptr_reg + 1'b1);
        end
        if (cmd.shift_wr)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.key_wr)
        begin
            mem_we  = 1'b1;
            wr_addr = lo_reg[AW-1:0];
            wr_data = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (mem_rd)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // divider
    logic [1:0]    div_ch_reg;
    logic [3:0]    div_cnt_reg;
    logic [SW-1:0] div_rem_reg;
    logic [7:0]    div_q_reg;
    logic [7:0]    mean_r_reg, mean_g_reg, mean_b_reg;
    logic [SW-1:0] div_src;
    logic [SW:0]   trial;
    logic [SW-1:0] dshift;

    always_comb
    begin
        unique case (div_ch_reg)
            2'd0:    div_src = sum_r_reg;
            2'd1:    div_src = sum_g_reg;
            default: div_src = sum_b_reg;
        endcase
    end

    assign dshift = SW'({{(SW-CW){1'b0}}, count_reg}) << (4'(DivSteps) - div_cnt_reg);
    assign trial  = {1'b0, div_rem_reg} - {1'b0, dshift};

    assign st.srch_done  = !(lo_reg < hi_reg);
    assign st.do_insert  = !func_reg && in_box && !full && !found;
    assign st.do_remove  = func_reg && found;
    assign st.shift_done = ins_reg ? (ptr_reg == lo_reg)
                                   : (ptr_reg + 1'b1 >= count_reg);
    assign st.div_done   = (div_ch_reg == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_r_reg  <= '0;
            sum_g_reg  <= '0;
            sum_b_reg  <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            ptr_reg    <= '0;
            ins_reg    <= 1'b0;
            rem_reg    <= 1'b0;
            div_ch_reg <= 2'd3;
            div_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                func_reg <= func;
                key_reg  <= {red, green, blue};
                lo_reg   <= '0;
                hi_reg   <= count_reg;
                ins_reg  <= 1'b0;
                rem_reg  <= 1'b0;
            end
            if (cmd.srch_cmp)
            begin
                if (rd_reg < key_reg)
                begin
                    lo_reg <= mid + 1'b1;
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            if (cmd.decide)
            begin
                status_reg <= func_reg ? scb_pkg::ST_NOT_FOUND : scb_pkg::ST_OUTSIDE;
            end
            if (cmd.shift_init)
            begin
                // rd_reg now holds entry at lo
                if (!func_reg)
                begin
                    if (!in_box)
                    begin
                        status_reg <= scb_pkg::ST_OUTSIDE;
                    end
                    else if (full)
                    begin
                        status_reg <= scb_pkg::ST_FULL;
                    end
                    else if (found)
                    begin
                        status_reg <= scb_pkg::ST_DUPLICATE;
                    end
                    else
                    begin
                        status_reg <= scb_pkg::ST_INSERTED;
                        ins_reg    <= 1'b1;
                    end
                    ptr_reg <= count_reg;
                end
                else
                begin
                    status_reg <= found ? scb_pkg::ST_REMOVED : scb_pkg::ST_NOT_FOUND;
                    rem_reg    <= found;
                    ptr_reg    <= lo_reg;
                end
            end
            if (cmd.shift_wr)
            begin
                ptr_reg <= ins_reg ? ptr_reg - 1'b1 : ptr_reg + 1'b1;
            end
            if (cmd.commit)
            begin
                if (ins_reg)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_r_reg <= sum_r_reg + SW'(key_reg[23:16]);
                    sum_g_reg <= sum_g_reg + SW'(key_reg[15:8]);
                    sum_b_reg <= sum_b_reg + SW'(key_reg[7:0]);
                end
                else
                begin
                    count_reg <= count_reg - 1'b1;
                    sum_r_reg <= sum_r_reg - SW'(key_reg[23:16]);
                    sum_g_reg <= sum_g_reg - SW'(key_reg[15:8]);
                    sum_b_reg <= sum_b_reg - SW'(key_reg[7:0]);
                end
            end
            if (cmd.div_start)
            begin
                div_ch_reg  <= 2'd0;
                div_cnt_reg <= '0;
            end
            if (cmd.div_step)
            begin
                if (div_cnt_reg == 4'd0)
                begin
                    div_rem_reg <= div_src;
                    div_q_reg   <= '0;
                    div_cnt_reg <= 4'd1;
                end
                else
                begin
                    if (!trial[SW])
                    begin
                        div_rem_reg <= trial[SW-1:0];
                    end
                    div_q_reg   <= {div_q_reg[6:0], ~trial[SW]};
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 4'(DivSteps))
                    begin
                        div_cnt_reg <= '0;
                        div_ch_reg  <= div_ch_reg + 1'b1;
                    end
                end
            end
        end
    end

    // restoring steps use count shifted by (DivSteps-1 - (cnt-1))
    logic [7:0] q_final;
    assign q_final = (count_reg == '0) ? 8'd0 : {div_q_reg[6:0], ~trial[SW]};

    always_ff @(posedge clk)
    begin
        if (cmd.div_step && div_cnt_reg == 4'(DivSteps))
        begin
            unique case (div_ch_reg)
                2'd0:    mean_r_reg <= q_final;
                2'd1:    mean_g_reg <= q_final;
                default: mean_b_reg <= q_final;
            endcase
        end
    end

    assign status      = status_reg;
    assign point_count = 9'(count_reg);
    assign mean_red    = mean_r_reg;
    assign mean_green  = mean_g_reg;
    assign mean_blue   = mean_b_reg;

    ap_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(scb_pkg::MaxPoints))
        else $error("count exceeds store depth");
    ap_srch_win: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg || st.srch_done)
        else $error("search window inverted");
    ap_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ins_reg && rem_reg))
        else $error("insert and remove both set");

endmodule
`default_nettype wire

>>> rtl/core/sorted_color_bucket.sv
// ----------------------------------------------------------------------------
// sorted_color_bucket: sorted set of RGB points with running mean color
// Usage:
//   Input channel in_valid/in_stall carries func, red, green, blue. Insert
//   (func 0) places a point in ascending red:green:blue order when it lies in
//   the configured box and the bucket is not full; remove (func 1) deletes it.
//   Output channel out_valid/out_stall carries status, point_count and the
//   truncated mean color, one result beat per input beat.
//   Per beat: a load, per binary search step a read and a compare, a step
//   to end the search, a decide, per moved entry a read and a write, a
//   step to end the shift on insert or remove, serial division for the
//   three means and an output step. One beat is in flight at a time.
//   cfg_we/cfg_index/cfg_data write the box and capacity registers; the
//   user must write them only while idle, the block does not enforce it.
//   Reset clears the point count and sums; the store itself is not cleared.
//   A stalled result holds and no new beat is taken until it leaves.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_color_bucket (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       func,
    input  wire logic [7:0] red,
    input  wire logic [7:0] green,
    input  wire logic [7:0] blue,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [2:0]      status,
    output logic [8:0]      point_count,
    output logic [7:0]      mean_red,
    output logic [7:0]      mean_green,
    output logic [7:0]      mean_blue,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [8:0] cfg_data
);

    scb_pkg::cmd_t  cmd;
    scb_pkg::stat_t st;

    scb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .st        (st),
        .cmd       (cmd)
    );

    scb_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .st          (st),
        .func        (func),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .point_count (point_count),
        .mean_red    (mean_red),
        .mean_green  (mean_green),
        .mean_blue   (mean_blue)
    );

endmodule
`default_nettype wire

>>> test/tb_sorted_color_bucket.sv
// ----------------------------------------------------------------------------
// tb_sorted_color_bucket: self-checking bench for the sorted color bucket
// Drives insert and remove beats under bursty input and a stalling output,
// predicts status, count and mean color from a sorted point list of its
// own, and compares every result beat in order. Box and capacity registers
// are changed between phases once the bucket has drained.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_sorted_color_bucket;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam logic       OP_INSERT  = 1'b0;
    localparam logic       OP_REMOVE  = 1'b1;
    localparam int         WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] count;
        logic [7:0] mr;
        logic [7:0] mg;
        logic [7:0] mb;
    } bucket_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       func = 1'b0;
    logic [7:0] red = '0, green = '0, blue = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] status;
    logic [8:0] point_count;
    logic [7:0] mean_red, mean_green, mean_blue;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [8:0] cfg_data = '0;

    sorted_color_bucket dut (.*);

    always #6 clk = ~clk;

    // bucket mirror
    logic [23:0]    held_pts[$];
    int             sum_r, sum_g, sum_b;
    int             low_r, low_g, low_b, size_r, size_g, size_b, cap;
    bucket_result_t pending_results[$];
    int             mismatches;
    int             idle_cycles;
    int             stall_mode;
    logic [23:0]    point_pool[$];

    function automatic bit in_box(int v, int lo, int sz);
        return v >= lo && v < lo + sz;
    endfunction

    function automatic void predict_bucket(logic op, logic [7:0] r, logic [7:0] g,
                                           logic [7:0] b);
        logic [23:0]    key;
        int             pos;
        bit             found;
        int             lim;
        bucket_result_t res;
        key = {r, g, b};
        pos = 0;
        while (pos < held_pts.size() && held_pts[pos] < key)
            pos++;
        found = pos < held_pts.size() && held_pts[pos] == key;
        lim = cap < scb_pkg::MaxPoints ? cap : scb_pkg::MaxPoints;
        if (op == OP_INSERT) begin
            if (!(in_box(r, low_r, size_r) && in_box(g, low_g, size_g) &&
                  in_box(b, low_b, size_b)))
                res.status = scb_pkg::ST_OUTSIDE;
            else if (held_pts.size() >= lim)
                res.status = scb_pkg::ST_FULL;
            else if (found)
                res.status = scb_pkg::ST_DUPLICATE;
            else begin
                held_pts.insert(pos, key);
                sum_r += r; sum_g += g; sum_b += b;
                res.status = scb_pkg::ST_INSERTED;
            end
        end else if (found) begin
            held_pts.delete(pos);
            sum_r -= r; sum_g -= g; sum_b -= b;
            res.status = scb_pkg::ST_REMOVED;
        end else
            res.status = scb_pkg::ST_NOT_FOUND;
        res.count = 9'(held_pts.size());
        if (held_pts.size() == 0) begin
            res.mr = '0; res.mg = '0; res.mb = '0;
        end else begin
            res.mr = 8'(sum_r / held_pts.size());
            res.mg = 8'(sum_g / held_pts.size());
            res.mb = 8'(sum_b / held_pts.size());
        end
        pending_results.insert(pending_results.size(), res);
    endfunction

    task automatic send_point(logic op, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        @(negedge clk);
        in_valid = 1'b1;
        func = op; red = r; green = g; blue = b;
        do @(posedge clk); while (in_stall);
        predict_bucket(op, r, g, b);
    endtask

    task automatic pause_sender(int n);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain;
        pause_sender(0);
        wait (pending_results.size() == 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [8:0] val);
        @(negedge clk);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            scb_pkg::REG_LOW_RED:    low_r = val[7:0];
            scb_pkg::REG_LOW_GREEN:  low_g = val[7:0];
            scb_pkg::REG_LOW_BLUE:   low_b = val[7:0];
            scb_pkg::REG_SIZE_RED:   size_r = val;
            scb_pkg::REG_SIZE_GREEN: size_g = val;
            scb_pkg::REG_SIZE_BLUE:  size_b = val;
            scb_pkg::REG_CAPACITY:   cap = val;
            default: ;
        endcase
    endtask

    task automatic set_box(int lr, int lg, int lb, int sr, int sg, int sb, int c);
        drain();
        write_reg(scb_pkg::REG_LOW_RED, 9'(lr));
        write_reg(scb_pkg::REG_LOW_GREEN, 9'(lg));
        write_reg(scb_pkg::REG_LOW_BLUE, 9'(lb));
        write_reg(scb_pkg::REG_SIZE_RED, 9'(sr));
        write_reg(scb_pkg::REG_SIZE_GREEN, 9'(sg));
        write_reg(scb_pkg::REG_SIZE_BLUE, 9'(sb));
        write_reg(scb_pkg::REG_CAPACITY, 9'(c));
    endtask

    task automatic empty_bucket;
        while (held_pts.size() > 0)
            send_point(OP_REMOVE, held_pts[0][23:16], held_pts[0][15:8], held_pts[0][7:0]);
    endtask

    task automatic test_basic_ops;
        send_point(OP_REMOVE, 8'd0, 8'd0, 8'd0);
        send_point(OP_INSERT, 8'd0, 8'd0, 8'd0);
        send_point(OP_INSERT, 8'd255, 8'd255, 8'd255);
        send_point(OP_INSERT, 8'd255, 8'd255, 8'd255);
        send_point(OP_INSERT, 8'd128, 8'd0, 8'd255);
        send_point(OP_INSERT, 8'd128, 8'd0, 8'd1);
        send_point(OP_INSERT, 8'd128, 8'd255, 8'd0);
        send_point(OP_INSERT, 8'h55, 8'hAA, 8'h55);
        send_point(OP_INSERT, 8'hAA, 8'h55, 8'hAA);
        send_point(OP_REMOVE, 8'd128, 8'd0, 8'd1);
        send_point(OP_REMOVE, 8'd128, 8'd0, 8'd1);
        send_point(OP_REMOVE, 8'd0, 8'd0, 8'd0);
        send_point(OP_REMOVE, 8'd255, 8'd255, 8'd254);
        empty_bucket();
    endtask

    task automatic test_box_edges;
        // zero size on one axis, bit 8 of data on a low register
        set_box(9'h1FF, 0, 0, 256, 0, 256, 256);
        send_point(OP_INSERT, 8'd255, 8'd0, 8'd0);
        drain();
        write_reg(REG_UNUSED, 9'h1FF);
        set_box(10, 20, 30, 5, 6, 7, 256);
        send_point(OP_INSERT, 8'd10, 8'd20, 8'd30);
        send_point(OP_INSERT, 8'd14, 8'd25, 8'd36);
        send_point(OP_INSERT, 8'd15, 8'd20, 8'd30);
        send_point(OP_INSERT, 8'd10, 8'd19, 8'd30);
        send_point(OP_INSERT, 8'd10, 8'd20, 8'd37);
        // box reaching past 255
        set_box(200, 200, 200, 511, 511, 511, 256);
        send_point(OP_INSERT, 8'd255, 8'd200, 8'd255);
        send_point(OP_INSERT, 8'd199, 8'd255, 8'd255);
        empty_bucket();
    endtask

    task automatic test_capacity;
        set_box(0, 0, 0, 256, 256, 256, 0);
        send_point(OP_INSERT, 8'd1, 8'd2, 8'd3);
        set_box(0, 0, 0, 256, 256, 256, 2);
        send_point(OP_INSERT, 8'd1, 8'd2, 8'd3);
        send_point(OP_INSERT, 8'd3, 8'd2, 8'd1);
        send_point(OP_INSERT, 8'd1, 8'd2, 8'd3);
        send_point(OP_INSERT, 8'd9, 8'd9, 8'd9);
        empty_bucket();
        // saturate at the store depth
        set_box(0, 0, 0, 256, 256, 256, 511);
        for (int i = 0; i < scb_pkg::MaxPoints; i++)
            send_point(OP_INSERT, 8'(255 - i), 8'(i * 7), 8'(i * 13));
        send_point(OP_INSERT, 8'd0, 8'd1, 8'd2);
        send_point(OP_INSERT, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic test_random_traffic;
        int          burst;
        int          pick;
        logic [23:0] p;
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 3))
                0: set_box(0, 0, 0, 256, 256, 256, 256);
                1: set_box($urandom_range(0, 511), $urandom_range(0, 511),
                           $urandom_range(0, 511), $urandom_range(0, 511),
                           $urandom_range(0, 511), $urandom_range(0, 511),
                           $urandom_range(0, 511));
                2: set_box($urandom_range(0, 64), $urandom_range(0, 64),
                           $urandom_range(0, 64), $urandom_range(128, 300),
                           $urandom_range(128, 300), $urandom_range(128, 300),
                           $urandom_range(0, 24));
                default: set_box(0, 0, 0, 256, 256, 256, $urandom_range(4, 40));
            endcase
            point_pool.delete();
            for (int i = 0; i < 24; i++)
                point_pool.insert(point_pool.size(),
                                  {8'(low_r + $urandom_range(0, 15)),
                                   8'(low_g + $urandom_range(0, 15)),
                                   8'(low_b + $urandom_range(0, 15))});
            burst = $urandom_range(1, 12);
            for (int n = 0; n < 20; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    p = point_pool[$urandom_range(0, point_pool.size() - 1)];
                else if (pick < 75 && held_pts.size() > 0)
                    p = held_pts[$urandom_range(0, held_pts.size() - 1)];
                else
                    p = 24'($urandom_range(0, 24'hFFFFFF));
                send_point((pick >= 45 && pick < 75) || pick >= 92 ? OP_REMOVE : OP_INSERT,
                           p[23:16], p[15:8], p[7:0]);
                if (--burst == 0) begin
                    pause_sender($urandom_range(0, 20));
                    burst = $urandom_range(1, 12);
                end
            end
        end
    endtask

    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= $urandom_range(0, 3) == 0;
            default: out_stall <= $urandom_range(0, 3) != 0;
        endcase
    end

    always @(posedge clk)
    begin
        bucket_result_t want;
        if (out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: status %0d count %0d",
                             status, point_count);
            end else begin
                want = pending_results.pop_front();
                if (want != {status, point_count, mean_red, mean_green, mean_blue}) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp st %0d cnt %0d mean %0d/%0d/%0d",
                                 want.status, want.count, want.mr, want.mg, want.mb);
                        $display("          got st %0d cnt %0d mean %0d/%0d/%0d",
                                 status, point_count, mean_red, mean_green, mean_blue);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0; idle_cycles = 0; stall_mode = 0;
        sum_r = 0; sum_g = 0; sum_b = 0;
        low_r = 0; low_g = 0; low_b = 0;
        size_r = 256; size_g = 256; size_b = 256; cap = 256;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        test_basic_ops();
        test_box_edges();
        test_capacity();
        test_random_traffic();
        drain();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
